// ----- src/ccv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccv_pkg
// Shared widths and reset values of the circle collision velocity update.
// ----------------------------------------------------------------------------
package ccv_pkg;
  localparam int CCV_COORD_WIDTH = 32;
  localparam int MASS_W          = 24;
  localparam int REST_W          = 17;
  localparam logic [REST_W-1:0] REST_RESET = 17'h10000;
endpackage
`default_nettype wire

// ----- src/ccv_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccv_in_if
// Input channel: one collision pair per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccv_in_if #(parameter int CW = ccv_pkg::CCV_COORD_WIDTH);
  import ccv_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MASS_W-1:0]    mass_a;
  logic [MASS_W-1:0]    mass_b;
  logic signed [CW-1:0] pos_a_x;
  logic signed [CW-1:0] pos_a_y;
  logic signed [CW-1:0] pos_b_x;
  logic signed [CW-1:0] pos_b_y;
  logic signed [CW-1:0] vel_a_x_in;
  logic signed [CW-1:0] vel_a_y_in;
  logic signed [CW-1:0] vel_b_x_in;
  logic signed [CW-1:0] vel_b_y_in;

  modport source (
    output valid, mass_a, mass_b, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
           vel_a_x_in, vel_a_y_in, vel_b_x_in, vel_b_y_in,
    input  ready
  );
  modport sink (
    input  valid, mass_a, mass_b, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
           vel_a_x_in, vel_a_y_in, vel_b_x_in, vel_b_y_in,
    output ready
  );
endinterface
`default_nettype wire

// ----- src/ccv_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccv_out_if
// Result channel: updated velocities per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccv_out_if #(parameter int CW = ccv_pkg::CCV_COORD_WIDTH);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] vel_a_x_out;
  logic signed [CW-1:0] vel_a_y_out;
  logic signed [CW-1:0] vel_b_x_out;
  logic signed [CW-1:0] vel_b_y_out;
  logic                 updated;

  modport source (
    output valid, vel_a_x_out, vel_a_y_out, vel_b_x_out, vel_b_y_out, updated,
    input  ready
  );
  modport sink (
    input  valid, vel_a_x_out, vel_a_y_out, vel_b_x_out, vel_b_y_out, updated,
    output ready
  );
endinterface
`default_nettype wire

// ----- src/circle_collision_velocity_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_collision_velocity_update
// Velocities of two circles after an impact with restitution.
// ----------------------------------------------------------------------------
// in_ch carries one pair per item (masses, centres, velocities); out_ch
// returns the four new velocities and the updated flag, in input order.
// Both are valid/ready channels; an item moves when valid and ready are high.
// cfg_we/cfg_wdata write the restitution factor (Q1.16); write it only while
// no item is in flight. Reset sets it to 1.0 and empties all queues.
// Throughput is one item per cycle while in_ch.ready is high. From acceptance
// to out_ch.valid an item passes through the input queue,
// three five-stage multiplier groups each followed by an add stage,
// a restoring divider producing one quotient bit per stage, and the read
// stage and output register of the result buffer.
// When the receiver stalls, results collect in the result buffer; a credit
// count over items in flight and buffered keeps it from overflowing, and
// in_ch.ready drops once the four-entry input queue fills behind it.
// ----------------------------------------------------------------------------
module circle_collision_velocity_update #(
  parameter int COORD_WIDTH = ccv_pkg::CCV_COORD_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ccv_in_if.sink                     in_ch,
  ccv_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [ccv_pkg::REST_W-1:0] cfg_wdata
);
  import ccv_pkg::*;

  logic [REST_W-1:0] rest_r;

  logic                          q_valid, q_ready, q_nz;
  logic [MASS_W-1:0]             q_ma, q_mb;
  logic signed [COORD_WIDTH:0]   q_rx, q_ry, q_ux, q_uy;
  logic signed [COORD_WIDTH-1:0] q_vax, q_vay, q_vbx, q_vby;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= REST_RESET;
    end else if (cfg_we) begin
      rest_r <= cfg_wdata;
    end
  end

  ccv_front #(.CW(COORD_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_ready(q_ready),
    .q_ma(q_ma), .q_mb(q_mb), .q_rx(q_rx), .q_ry(q_ry), .q_ux(q_ux), .q_uy(q_uy),
    .q_vax(q_vax), .q_vay(q_vay), .q_vbx(q_vbx), .q_vby(q_vby), .q_nz(q_nz)
  );

  ccv_back #(.CW(COORD_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .restitution(rest_r),
    .q_valid(q_valid), .q_ready(q_ready),
    .q_ma(q_ma), .q_mb(q_mb), .q_rx(q_rx), .q_ry(q_ry), .q_ux(q_ux), .q_uy(q_uy),
    .q_vax(q_vax), .q_vay(q_vay), .q_vbx(q_vbx), .q_vby(q_vby), .q_nz(q_nz),
    .out_ch(out_ch)
  );
endmodule
`default_nettype wire

// ----- src/ccv_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccv_mul
// Pipelined signed multiplier: b is consumed one chunk per stage, with a
// sideband that travels along with the product.
// ----------------------------------------------------------------------------
module ccv_mul #(
  parameter int WA     = 8,
  parameter int WB     = 8,
  parameter int STAGES = 3,
  parameter int SW     = 1
) (
  input  logic                    clk,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  input  logic [SW-1:0]           side_in,
  output logic signed [WA+WB-1:0] p,
  output logic [SW-1:0]           side_out
);
  localparam int CH = (WB + STAGES - 1) / STAGES;
  localparam int BW = CH * STAGES;
  localparam int PW = WA + WB;

  logic signed [WA-1:0] a_r   [STAGES];
  logic signed [BW-1:0] b_r   [STAGES];
  logic signed [PW-1:0] acc_r [STAGES];
  logic [SW-1:0]        side_r[STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    logic signed [WA-1:0] a_i;
    logic signed [BW-1:0] b_i;
    logic signed [PW-1:0] acc_i;
    logic [SW-1:0]        s_i;
    logic signed [CH:0]   chunk_s;
    logic signed [WA+CH:0] prod;

    if (i == 0) begin : g_first
      assign a_i   = a;
      assign b_i   = BW'(b);
      assign acc_i = '0;
      assign s_i   = side_in;
    end else begin : g_next
      assign a_i   = a_r[i-1];
      assign b_i   = b_r[i-1];
      assign acc_i = acc_r[i-1];
      assign s_i   = side_r[i-1];
    end

    // top chunk carries the sign, the others are magnitudes
    if (i == STAGES - 1) begin : g_top
      assign chunk_s = $signed({b_i[i*CH+CH-1], b_i[i*CH +: CH]});
    end else begin : g_low
      assign chunk_s = $signed({1'b0, b_i[i*CH +: CH]});
    end

    assign prod = a_i * chunk_s;

    always_ff @(posedge clk) begin
      a_r[i]    <= a_i;
      b_r[i]    <= b_i;
      acc_r[i]  <= acc_i + (PW'(prod) <<< (i * CH));
      side_r[i] <= s_i;
    end
  end

  assign p        = acc_r[STAGES-1];
  assign side_out = side_r[STAGES-1];
endmodule
`default_nettype wire

// ----- src/ccv_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccv_div
// Pipelined restoring divider: floor(n / d) for d > 0, saturated to QW
// signed bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module ccv_div #(
  parameter int NW  = 16,
  parameter int DNW = 8,
  parameter int QW  = 8,
  parameter int SW  = 1
) (
  input  logic                 clk,
  input  logic signed [NW-1:0] n,
  input  logic [DNW-1:0]       d,
  input  logic [SW-1:0]        side_in,
  output logic signed [QW-1:0] q,
  output logic [SW-1:0]        side_out
);
  localparam int XW = ((NW > DNW + QW) ? NW : DNW + QW) + 1;
  localparam logic [QW:0]   HALF = (QW + 1)'(1) << (QW - 1);
  localparam logic [QW-1:0] MAXP = QW'(HALF - (QW + 1)'(1));
  localparam logic [QW-1:0] MINN = QW'(HALF);

  logic [NW-1:0]  mag_c;
  logic [NW-1:0]  mag0_r;
  logic           neg0_r;
  logic [DNW-1:0] d0_r;
  logic [SW-1:0]  s0_r;

  logic [XW-1:0]  rem_r [QW+1];
  logic [QW-1:0]  quo_r [QW+1];
  logic [DNW-1:0] d_r   [QW+1];
  logic           neg_r [QW+1];
  logic           ovf_r [QW+1];
  logic [SW-1:0]  s_r   [QW+1];

  logic           rnz;
  logic [QW:0]    qn;
  logic signed [QW-1:0] q_nxt;
  logic signed [QW-1:0] q_r;
  logic [SW-1:0]  so_r;

  assign mag_c = n[NW-1] ? $unsigned(-n) : $unsigned(n);

  always_ff @(posedge clk) begin
    mag0_r <= mag_c;
    neg0_r <= n[NW-1];
    d0_r   <= d;
    s0_r   <= side_in;
  end

  // flag quotients that do not fit QW magnitude bits
  always_ff @(posedge clk) begin
    rem_r[0] <= XW'(mag0_r);
    quo_r[0] <= '0;
    d_r[0]   <= d0_r;
    neg_r[0] <= neg0_r;
    ovf_r[0] <= XW'(mag0_r) >= (XW'(d0_r) << QW);
    s_r[0]   <= s0_r;
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    logic [XW-1:0] sh;
    logic          take;
    assign sh   = XW'(d_r[j]) << (QW - 1 - j);
    assign take = rem_r[j] >= sh;
    always_ff @(posedge clk) begin
      rem_r[j+1] <= take ? rem_r[j] - sh : rem_r[j];
      quo_r[j+1] <= quo_r[j] | (take ? (QW'(1) << (QW - 1 - j)) : '0);
      d_r[j+1]   <= d_r[j];
      neg_r[j+1] <= neg_r[j];
      ovf_r[j+1] <= ovf_r[j];
      s_r[j+1]   <= s_r[j];
    end
  end

  assign rnz = rem_r[QW] != '0;
  assign qn  = (QW + 1)'(quo_r[QW]) + (QW + 1)'(rnz);

  always_comb begin
    if (neg_r[QW]) begin
      if (ovf_r[QW] || qn > HALF) q_nxt = $signed(MINN);
      else                        q_nxt = $signed(QW'(-qn));
    end else begin
      if (ovf_r[QW] || quo_r[QW][QW-1]) q_nxt = $signed(MAXP);
      else                              q_nxt = $signed(quo_r[QW]);
    end
  end

  always_ff @(posedge clk) begin
    q_r  <= q_nxt;
    so_r <= s_r[QW];
  end

  assign q        = q_r;
  assign side_out = so_r;
endmodule
`default_nettype wire

// ----- src/ccv_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccv_front
// Accepts pairs, forms relative position and velocity, flags the zero-mass
// case and queues the item for the arithmetic back end.
// ----------------------------------------------------------------------------
module ccv_front #(
  parameter int CW = ccv_pkg::CCV_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ccv_in_if.sink                        in_ch,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic [ccv_pkg::MASS_W-1:0]    q_ma,
  output logic [ccv_pkg::MASS_W-1:0]    q_mb,
  output logic signed [CW:0]            q_rx,
  output logic signed [CW:0]            q_ry,
  output logic signed [CW:0]            q_ux,
  output logic signed [CW:0]            q_uy,
  output logic signed [CW-1:0]          q_vax,
  output logic signed [CW-1:0]          q_vay,
  output logic signed [CW-1:0]          q_vbx,
  output logic signed [CW-1:0]          q_vby,
  output logic                          q_nz
);
  import ccv_pkg::*;

  localparam int DW  = CW + 1;
  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);
  localparam int EW  = 2 * MASS_W + 4 * DW + 4 * CW + 1;

  logic [EW-1:0]  ent_r [QD];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push, pop;
  logic signed [DW-1:0] rx, ry, ux, uy;
  logic           nz;

  assign in_ch.ready = cnt_r != (QAW + 1)'(QD);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = cnt_r != '0;
  assign pop  = q_valid && q_ready;

  assign rx = DW'(in_ch.pos_b_x) - DW'(in_ch.pos_a_x);
  assign ry = DW'(in_ch.pos_b_y) - DW'(in_ch.pos_a_y);
  assign ux = DW'(in_ch.vel_b_x_in) - DW'(in_ch.vel_a_x_in);
  assign uy = DW'(in_ch.vel_b_y_in) - DW'(in_ch.vel_a_y_in);
  assign nz = (in_ch.mass_a != '0) || (in_ch.mass_b != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= {in_ch.mass_a, in_ch.mass_b, rx, ry, ux, uy,
                      in_ch.vel_a_x_in, in_ch.vel_a_y_in,
                      in_ch.vel_b_x_in, in_ch.vel_b_y_in, nz};
    end
  end

  assign {q_ma, q_mb, q_rx, q_ry, q_ux, q_uy, q_vax, q_vay, q_vbx, q_vby, q_nz} =
    ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r + (QAW + 1)'(push) - (QAW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- src/ccv_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccv_back
// Fixed-latency arithmetic pipeline (products, impulse, momentum, four
// dividers) feeding a credit-guarded result buffer.
// ----------------------------------------------------------------------------
module ccv_back #(
  parameter int CW = ccv_pkg::CCV_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ccv_pkg::REST_W-1:0]    restitution,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [ccv_pkg::MASS_W-1:0]    q_ma,
  input  logic [ccv_pkg::MASS_W-1:0]    q_mb,
  input  logic signed [CW:0]            q_rx,
  input  logic signed [CW:0]            q_ry,
  input  logic signed [CW:0]            q_ux,
  input  logic signed [CW:0]            q_uy,
  input  logic signed [CW-1:0]          q_vax,
  input  logic signed [CW-1:0]          q_vay,
  input  logic signed [CW-1:0]          q_vbx,
  input  logic signed [CW-1:0]          q_vby,
  input  logic                          q_nz,
  ccv_out_if.source                     out_ch
);
  import ccv_pkg::*;

  localparam int MUL_ST = 5;
  localparam int DW   = CW + 1;
  localparam int D2W  = 2 * DW + 1;
  localparam int MSW  = MASS_W + 1;
  localparam int MMW  = MASS_W + 2;
  localparam int RSW  = REST_W + 1;
  localparam int RAW  = RSW + MSW;
  localparam int PXW  = MSW + CW + 1;
  localparam int VW   = 4 * CW;
  localparam int WXW  = D2W + DW + 2;
  localparam int BXW  = D2W + PXW + 16;
  localparam int DENW = D2W + MMW + 16;
  localparam int NW   = ((BXW > WXW + RAW) ? BXW : WXW + RAW) + 1;
  localparam int SAW  = 4 * DW + MMW + VW + 1;
  localparam int SBW  = 2 * RAW + VW + 1;
  localparam int SCW  = 2 * BXW + DENW + VW + 1;
  localparam int SDW  = VW + 1;
  localparam int LAT  = 3 * MUL_ST + 3 + CW + 3;
  localparam int MEMD = 2 ** $clog2(LAT + 4);
  localparam int AW   = $clog2(MEMD);
  localparam int CNTW = $clog2(MEMD + 1);

  // ---------------- issue and credit ----------------
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            issue, out_hs;
  logic [LAT-1:0]  vld_r, vld_nxt;

  assign q_ready = cnt_r < CNTW'(MEMD);
  assign issue   = q_valid && q_ready;
  assign out_hs  = out_ch.valid && out_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r + CNTW'(issue) - CNTW'(out_hs);
    vld_nxt = {vld_r[LAT-2:0], issue};
  end

  // ---------------- products of the first group ----------------
  logic signed [MSW-1:0] ma_s, mb_s;
  logic signed [RSW-1:0] rest_s;
  logic [MMW-1:0]        m_sum;
  logic [SAW-1:0]        sa_in, sa_out;
  logic signed [2*DW-1:0]    p_uxrx, p_uyry, p_rxrx, p_ryry;
  logic signed [MSW+CW-1:0]  p_max, p_mbx, p_may, p_mby;
  logic signed [RAW-1:0]     p_ra, p_rb;

  assign ma_s   = $signed({1'b0, q_ma});
  assign mb_s   = $signed({1'b0, q_mb});
  assign rest_s = $signed({1'b0, restitution});
  assign m_sum  = MMW'(q_ma) + MMW'(q_mb);
  assign sa_in  = {q_rx, q_ry, q_ux, q_uy, m_sum, q_vax, q_vay, q_vbx, q_vby, q_nz};

  ccv_mul #(.WA(DW), .WB(DW), .STAGES(MUL_ST), .SW(SAW)) u_a_uxrx (
    .clk(clk), .a(q_ux), .b(q_rx), .side_in(sa_in), .p(p_uxrx), .side_out(sa_out));
  ccv_mul #(.WA(DW), .WB(DW), .STAGES(MUL_ST), .SW(1)) u_a_uyry (
    .clk(clk), .a(q_uy), .b(q_ry), .side_in(1'b0), .p(p_uyry), .side_out());
  ccv_mul #(.WA(DW), .WB(DW), .STAGES(MUL_ST), .SW(1)) u_a_rxrx (
    .clk(clk), .a(q_rx), .b(q_rx), .side_in(1'b0), .p(p_rxrx), .side_out());
  ccv_mul #(.WA(DW), .WB(DW), .STAGES(MUL_ST), .SW(1)) u_a_ryry (
    .clk(clk), .a(q_ry), .b(q_ry), .side_in(1'b0), .p(p_ryry), .side_out());
  ccv_mul #(.WA(MSW), .WB(CW), .STAGES(MUL_ST), .SW(1)) u_a_max (
    .clk(clk), .a(ma_s), .b(q_vax), .side_in(1'b0), .p(p_max), .side_out());
  ccv_mul #(.WA(MSW), .WB(CW), .STAGES(MUL_ST), .SW(1)) u_a_mbx (
    .clk(clk), .a(mb_s), .b(q_vbx), .side_in(1'b0), .p(p_mbx), .side_out());
  ccv_mul #(.WA(MSW), .WB(CW), .STAGES(MUL_ST), .SW(1)) u_a_may (
    .clk(clk), .a(ma_s), .b(q_vay), .side_in(1'b0), .p(p_may), .side_out());
  ccv_mul #(.WA(MSW), .WB(CW), .STAGES(MUL_ST), .SW(1)) u_a_mby (
    .clk(clk), .a(mb_s), .b(q_vby), .side_in(1'b0), .p(p_mby), .side_out());
  ccv_mul #(.WA(RSW), .WB(MSW), .STAGES(MUL_ST), .SW(1)) u_a_ra (
    .clk(clk), .a(rest_s), .b(mb_s), .side_in(1'b0), .p(p_ra), .side_out());
  ccv_mul #(.WA(RSW), .WB(MSW), .STAGES(MUL_ST), .SW(1)) u_a_rb (
    .clk(clk), .a(rest_s), .b(ma_s), .side_in(1'b0), .p(p_rb), .side_out());

  logic signed [DW-1:0]  a_rx, a_ry, a_ux, a_uy;
  logic [MMW-1:0]        a_m;
  logic [VW-1:0]         a_v;
  logic                  a_nz;
  logic signed [D2W-1:0] dot_c;

  assign {a_rx, a_ry, a_ux, a_uy, a_m, a_v, a_nz} = sa_out;
  assign dot_c = D2W'(p_uxrx) + D2W'(p_uyry);

  logic signed [D2W-1:0] dot_r, d2_r;
  logic signed [PXW-1:0] px_r, py_r;
  logic signed [RAW-1:0] ra_r, rb_r;
  logic signed [DW-1:0]  rx_r, ry_r, ux_r, uy_r;
  logic [MMW-1:0]        m_r;
  logic [VW-1:0]         va_r;
  logic                  app_r;

  // approaching bodies with some mass get the impulse
  always_ff @(posedge clk) begin
    dot_r <= dot_c;
    d2_r  <= D2W'(p_rxrx) + D2W'(p_ryry);
    px_r  <= PXW'(p_max) + PXW'(p_mbx);
    py_r  <= PXW'(p_may) + PXW'(p_mby);
    ra_r  <= p_ra;
    rb_r  <= p_rb;
    rx_r  <= a_rx;
    ry_r  <= a_ry;
    ux_r  <= a_ux;
    uy_r  <= a_uy;
    m_r   <= a_m;
    va_r  <= a_v;
    app_r <= dot_c[D2W-1] && a_nz;
  end

  // ---------------- products of the second group ----------------
  logic [SBW-1:0]            sb_in, sb_out;
  logic signed [D2W+DW-1:0]  p_uxd2, p_rxdot, p_uyd2, p_rydot;
  logic signed [D2W+PXW-1:0] p_d2px, p_d2py;
  logic signed [D2W+MMW-1:0] p_d2m;

  assign sb_in = {ra_r, rb_r, va_r, app_r};

  ccv_mul #(.WA(D2W), .WB(DW), .STAGES(MUL_ST), .SW(SBW)) u_b_uxd2 (
    .clk(clk), .a(d2_r), .b(ux_r), .side_in(sb_in), .p(p_uxd2), .side_out(sb_out));
  ccv_mul #(.WA(D2W), .WB(DW), .STAGES(MUL_ST), .SW(1)) u_b_rxdot (
    .clk(clk), .a(dot_r), .b(rx_r), .side_in(1'b0), .p(p_rxdot), .side_out());
  ccv_mul #(.WA(D2W), .WB(DW), .STAGES(MUL_ST), .SW(1)) u_b_uyd2 (
    .clk(clk), .a(d2_r), .b(uy_r), .side_in(1'b0), .p(p_uyd2), .side_out());
  ccv_mul #(.WA(D2W), .WB(DW), .STAGES(MUL_ST), .SW(1)) u_b_rydot (
    .clk(clk), .a(dot_r), .b(ry_r), .side_in(1'b0), .p(p_rydot), .side_out());
  ccv_mul #(.WA(D2W), .WB(PXW), .STAGES(MUL_ST), .SW(1)) u_b_d2px (
    .clk(clk), .a(d2_r), .b(px_r), .side_in(1'b0), .p(p_d2px), .side_out());
  ccv_mul #(.WA(D2W), .WB(PXW), .STAGES(MUL_ST), .SW(1)) u_b_d2py (
    .clk(clk), .a(d2_r), .b(py_r), .side_in(1'b0), .p(p_d2py), .side_out());
  ccv_mul #(.WA(D2W), .WB(MMW), .STAGES(MUL_ST), .SW(1)) u_b_d2m (
    .clk(clk), .a(d2_r), .b($signed(m_r)), .side_in(1'b0), .p(p_d2m), .side_out());

  logic signed [RAW-1:0] b_ra, b_rb;
  logic [VW-1:0]         b_v;
  logic                  b_app;

  assign {b_ra, b_rb, b_v, b_app} = sb_out;

  logic signed [WXW-1:0] wx_r, wy_r;
  logic signed [BXW-1:0] bx_r, by_r;
  logic [DENW-1:0]       den_r;
  logic signed [RAW-1:0] ra2_r, rb2_r;
  logic [VW-1:0]         vb_r;
  logic                  appb_r;

  // d2 * w = u * d2 - 2 * dot * r; momentum and denominator carry 2^16
  always_ff @(posedge clk) begin
    wx_r   <= WXW'(p_uxd2) - (WXW'(p_rxdot) <<< 1);
    wy_r   <= WXW'(p_uyd2) - (WXW'(p_rydot) <<< 1);
    bx_r   <= $signed({p_d2px, 16'b0});
    by_r   <= $signed({p_d2py, 16'b0});
    den_r  <= {p_d2m, 16'b0};
    ra2_r  <= b_ra;
    rb2_r  <= b_rb;
    vb_r   <= b_v;
    appb_r <= b_app;
  end

  // ---------------- products of the third group ----------------
  logic [SCW-1:0]             sc_in, sc_out;
  logic signed [WXW+RAW-1:0]  p_rawx, p_rawy, p_rbwx, p_rbwy;

  assign sc_in = {bx_r, by_r, den_r, vb_r, appb_r};

  ccv_mul #(.WA(WXW), .WB(RAW), .STAGES(MUL_ST), .SW(SCW)) u_c_rawx (
    .clk(clk), .a(wx_r), .b(ra2_r), .side_in(sc_in), .p(p_rawx), .side_out(sc_out));
  ccv_mul #(.WA(WXW), .WB(RAW), .STAGES(MUL_ST), .SW(1)) u_c_rawy (
    .clk(clk), .a(wy_r), .b(ra2_r), .side_in(1'b0), .p(p_rawy), .side_out());
  ccv_mul #(.WA(WXW), .WB(RAW), .STAGES(MUL_ST), .SW(1)) u_c_rbwx (
    .clk(clk), .a(wx_r), .b(rb2_r), .side_in(1'b0), .p(p_rbwx), .side_out());
  ccv_mul #(.WA(WXW), .WB(RAW), .STAGES(MUL_ST), .SW(1)) u_c_rbwy (
    .clk(clk), .a(wy_r), .b(rb2_r), .side_in(1'b0), .p(p_rbwy), .side_out());

  logic signed [BXW-1:0] c_bx, c_by;
  logic [DENW-1:0]       c_den;
  logic [VW-1:0]         c_v;
  logic                  c_app;

  assign {c_bx, c_by, c_den, c_v, c_app} = sc_out;

  logic signed [NW-1:0] nax_r, nay_r, nbx_r, nby_r;
  logic [DENW-1:0]      denc_r;
  logic [SDW-1:0]       sd_r;

  always_ff @(posedge clk) begin
    nax_r  <= NW'(c_bx) - NW'(p_rawx);
    nay_r  <= NW'(c_by) - NW'(p_rawy);
    nbx_r  <= NW'(c_bx) + NW'(p_rbwx);
    nby_r  <= NW'(c_by) + NW'(p_rbwy);
    denc_r <= c_den;
    sd_r   <= {c_v, c_app};
  end

  // ---------------- dividers ----------------
  logic signed [CW-1:0] q_ax, q_ay, q_bx, q_by;
  logic [SDW-1:0]       sd_out;
  logic [VW-1:0]        d_v;
  logic                 d_app;
  logic [SDW-1:0]       wdata;

  ccv_div #(.NW(NW), .DNW(DENW), .QW(CW), .SW(SDW)) u_div_ax (
    .clk(clk), .n(nax_r), .d(denc_r), .side_in(sd_r), .q(q_ax), .side_out(sd_out));
  ccv_div #(.NW(NW), .DNW(DENW), .QW(CW), .SW(1)) u_div_ay (
    .clk(clk), .n(nay_r), .d(denc_r), .side_in(1'b0), .q(q_ay), .side_out());
  ccv_div #(.NW(NW), .DNW(DENW), .QW(CW), .SW(1)) u_div_bx (
    .clk(clk), .n(nbx_r), .d(denc_r), .side_in(1'b0), .q(q_bx), .side_out());
  ccv_div #(.NW(NW), .DNW(DENW), .QW(CW), .SW(1)) u_div_by (
    .clk(clk), .n(nby_r), .d(denc_r), .side_in(1'b0), .q(q_by), .side_out());

  assign {d_v, d_app} = sd_out;
  // pass velocities through when the bodies do not approach or both masses are zero
  assign wdata = {d_app ? {q_ax, q_ay, q_bx, q_by} : d_v, d_app};

  // ---------------- result buffer ----------------
  logic [SDW-1:0]  mem [MEMD];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     mc_r, mc_nxt;
  logic            wr, rd_go, mv;
  logic [SDW-1:0]  rdd_r, od_r;
  logic            rdv_r, rdv_nxt, ov_r, ov_nxt;

  assign wr    = vld_r[LAT-1];
  assign mv    = rdv_r && (!ov_r || out_ch.ready);
  assign rd_go = (mc_r != '0) && (!rdv_r || mv);

  always_comb begin
    mc_nxt  = mc_r + (AW + 1)'(wr) - (AW + 1)'(rd_go);
    rdv_nxt = rd_go ? 1'b1 : (mv ? 1'b0 : rdv_r);
    if (mv)                ov_nxt = 1'b1;
    else if (out_ch.ready) ov_nxt = 1'b0;
    else                   ov_nxt = ov_r;
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_go) rdd_r <= mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (mv) od_r <= rdd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
      mc_r  <= '0;
      rdv_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
      wp_r  <= wr ? wp_r + AW'(1) : wp_r;
      rp_r  <= rd_go ? rp_r + AW'(1) : rp_r;
      mc_r  <= mc_nxt;
      rdv_r <= rdv_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign out_ch.valid = ov_r;
  assign {out_ch.vel_a_x_out, out_ch.vel_a_y_out, out_ch.vel_b_x_out,
          out_ch.vel_b_y_out, out_ch.updated} = od_r;
endmodule
`default_nettype wire
